@@ rtl/trial_division_primality_test_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the trial-division primality test unit.
// Each macro expands to one labelled concurrent assertion that is disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdp: next-cycle check failed");

`endif

@@ rtl/tdp_pkg.sv @@
// ----------------------------------------------------------------------------
// Trial-division primality test package
// Shared constants and types for the primality test unit and its remainder
// unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 16;
   localparam int RSP_TDATA_WIDTH     = 8;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_NEGATIVE = 2'd1,
      ERR_ZERO     = 2'd2
   } err_code_type;

   // Status returned by the remainder unit to the sequencer.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } rem_status_type;

endpackage

@@ rtl/tdp_rem_unit.sv @@
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial remainder: one dividend bit is shifted in per cycle
// and the divisor subtracted when it fits.
// ----------------------------------------------------------------------------
`include "trial_division_primality_test_unit_defines.svh"

module tdp_rem_unit #(
   parameter int VALUE_WIDTH = tdp_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     dividend,
   input  logic [VALUE_WIDTH-1:0]     divisor,
   output tdp_pkg::rem_status_type    status
);
   import tdp_pkg::*;

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(VALUE_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         // The partial remainder stays below the divisor, so both arms fit.
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
         end
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

   `TDP_ASSERT_SAME(a_no_start_busy, clock, reset, start, !busy_ff)
   `TDP_ASSERT_NEXT(a_done_idle, clock, reset, done_ff, !busy_ff || start)
   `TDP_ASSERT_SAME(a_divisor_nonzero, clock, reset, busy_ff, div_ff != '0)

endmodule

@@ rtl/trial_division_primality_test_unit.sv @@
// ----------------------------------------------------------------------------
// Trial-division primality test unit
// Decides whether a signed integer is prime by trying divisors from two
// upwards while the divisor squared does not exceed the value.
//
// Usage:
//   The req_ stream carries one value per word in req_tdata; the rsp_ stream
//   returns one word per value with is_prime and error_code. Negative values
//   and zero return an error code at once, with is_prime cleared.
//   Each divisor tried runs through the shared bit-serial remainder unit
//   after a compare step in S_CHECK, and up to floor(sqrt(n)) - 1
//   divisors are tried, so a prime near 2^(VALUE_WIDTH-1) takes the longest.
//   Errors and one go from S_IDLE straight to S_FIN; two and three pass one
//   S_CHECK step first, and S_FIN registers the result word.
//   req_tready is high only while no value is in work, so one value is
//   processed at a time, and req_tready rises again in the cycle after the
//   result is registered.
//   The result sits in an output register; a new value is taken while it
//   waits, and a finished test holds until rsp_tready frees that register.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "trial_division_primality_test_unit_defines.svh"

module trial_division_primality_test_unit #(
   parameter int VALUE_WIDTH = tdp_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [VALUE_WIDTH-1:0] value, upper bits zero
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] is_prime, [2:1] error_code, upper bits zero
   output logic [tdp_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata
);
   import tdp_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_DIV   = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [VALUE_WIDTH-1:0]       n_ff, n_in;
   logic [VALUE_WIDTH-1:0]       d_ff, d_in;
   logic [VALUE_WIDTH-1:0]       sq_ff, sq_in;
   logic                         prime_ff, prime_in;
   err_code_type                 err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic [VALUE_WIDTH-1:0]       raw;
   logic                         rem_start;
   logic                         out_free;
   rem_status_type               rem_status;

   assign raw        = req_tdata[VALUE_WIDTH-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   tdp_rem_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .status   (rem_status)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      prime_in  = prime_ff;
      err_in    = err_ff;
      rem_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               n_in     = raw;
               d_in     = VALUE_WIDTH'(2);
               sq_in    = VALUE_WIDTH'(4);
               prime_in = 1'b0;
               err_in   = ERR_OK;
               priority if (raw[VALUE_WIDTH-1]) begin
                  err_in   = ERR_NEGATIVE;
                  state_in = S_FIN;
               end else if (raw == '0) begin
                  err_in   = ERR_ZERO;
                  state_in = S_FIN;
               end else if (raw == ONE) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sq_ff > n_ff) begin
               prime_in = 1'b1;
               state_in = S_FIN;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_status.done) begin
               if (rem_status.rem_zero) begin
                  state_in = S_FIN;
               end else begin
                  // (d + 1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + {d_ff[VALUE_WIDTH-2:0], 1'b1};
                  d_in     = d_ff + ONE;
                  state_in = S_CHECK;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_FIN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_TDATA_WIDTH - 3){1'b0}}, err_ff, prime_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      prime_ff    <= prime_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TDP_ASSERT_SAME(a_done_in_div, clock, reset, rem_status.done, state_ff == S_DIV)
   `TDP_ASSERT_SAME(a_div_in_range, clock, reset, state_ff == S_DIV, sq_ff <= n_ff)
   `TDP_ASSERT_SAME(a_prime_no_err, clock, reset, rsp_valid_ff && rsp_data_ff[0],
      rsp_data_ff[2:1] == ERR_OK)
   `TDP_ASSERT_NEXT(a_start_busy, clock, reset, rem_start, state_ff == S_DIV)

endmodule

@@ test/tb_trial_division_primality_test_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the trial-division primality test unit
// A table of directed values comes first: zero, negative values, one, two,
// the largest positive value, squares of primes and large primes. Random
// values follow, weighted towards small and mid-range numbers, with large
// primes, squares and near-squares mixed in. Every result word is checked
// against a typed verdict or a local predictor of the block; both streams idle at random.
// ----------------------------------------------------------------------------
module tb_trial_division_primality_test_unit;
   import tdp_pkg::*;

   localparam int VW           = DEFAULT_VALUE_WIDTH;
   localparam int REQ_W        = ((VW + 7) / 8) * 8;
   localparam int N_DIRECTED   = 23;
   localparam int N_RANDOM     = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 8_000_000;

   typedef struct packed {
      logic         is_prime;
      err_code_type error_code;
   } verdict_type;

   typedef struct packed {
      logic [VW-1:0] value;
      logic          typed;
      verdict_type   verdict;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // [15:0] value
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;   // [0] is_prime, [2:1] error_code

   verdict_type expected_verdicts [$];
   int          mismatch_count = 0;
   int          idle_percent;
   int          cycle_count = 0;
   int          n_prime = 0;
   int          n_not_prime = 0;
   int          n_negative = 0;
   int          n_zero = 0;

   // Rows with the typed flag clear are checked against the predictor.
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{16'h0000, 1'b1, '{1'b0, ERR_ZERO}},
      '{16'hFFFF, 1'b1, '{1'b0, ERR_NEGATIVE}},
      '{16'h8000, 1'b1, '{1'b0, ERR_NEGATIVE}},
      '{16'hC000, 1'b1, '{1'b0, ERR_NEGATIVE}},
      '{16'hAAAA, 1'b1, '{1'b0, ERR_NEGATIVE}},
      '{16'h0001, 1'b1, '{1'b0, ERR_OK}},
      '{16'h0002, 1'b1, '{1'b1, ERR_OK}},
      '{16'h0003, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0004, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0009, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0011, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0019, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0031, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0061, 1'b0, '{1'b0, ERR_OK}},
      '{16'h00FF, 1'b0, '{1'b0, ERR_OK}},
      '{16'h0101, 1'b0, '{1'b0, ERR_OK}},
      '{16'h2AAA, 1'b0, '{1'b0, ERR_OK}},
      '{16'h4000, 1'b0, '{1'b0, ERR_OK}},
      '{16'h5555, 1'b0, '{1'b0, ERR_OK}},
      '{16'h7FF9, 1'b0, '{1'b0, ERR_OK}},
      '{16'h7FED, 1'b0, '{1'b0, ERR_OK}},
      '{16'h7FFE, 1'b0, '{1'b0, ERR_OK}},
      '{16'h7FFF, 1'b0, '{1'b0, ERR_OK}}
   };

   trial_division_primality_test_unit #(
      .VALUE_WIDTH(VW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Trial division stops once the divisor squared passes the value.
   function automatic verdict_type predict_verdict(logic [VW-1:0] value);
      verdict_type v;
      int unsigned n;
      v.is_prime   = 1'b0;
      v.error_code = ERR_OK;
      n = value;
      if (value[VW-1]) begin
         v.error_code = ERR_NEGATIVE;
      end else if (n == 0) begin
         v.error_code = ERR_ZERO;
      end else if (n >= 2) begin
         v.is_prime = 1'b1;
         for (int unsigned d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
               v.is_prime = 1'b0;
               break;
            end
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(logic [VW-1:0] value, logic typed, verdict_type typed_verdict);
      @(negedge clock);
      while ($urandom_range(99) < idle_percent) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_verdicts.push_back(typed ? typed_verdict : predict_verdict(value));
   endtask

   task automatic wait_for_results();
      while (expected_verdicts.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_percent);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("result word with nothing outstanding", rsp_tdata, 0);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== want.is_prime)
               report_mismatch("is_prime", rsp_tdata[0], want.is_prime);
            if (rsp_tdata[2:1] !== want.error_code)
               report_mismatch("error_code", rsp_tdata[2:1], want.error_code);
            case (want.error_code)
               ERR_NEGATIVE: n_negative++;
               ERR_ZERO:     n_zero++;
               default: begin
                  if (want.is_prime) n_prime++;
                  else n_not_prime++;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding", expected_verdicts.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int            sel;
      int unsigned   a;
      logic [VW-1:0] v;
      verdict_type   vd;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      idle_percent   = 28;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].verdict);
      end

      // Hold the request side off until every answer so far has been returned.
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_for_results();

      for (int i = 0; i < N_RANDOM; i++) begin
         // A stretch in the middle runs with both sides always ready.
         idle_percent = (i >= 150 && i < 230) ? 0 : 28;
         sel = $urandom_range(99);
         if (sel < 35) begin
            v = VW'($urandom_range(0, 65535));
         end else if (sel < 65) begin
            v = VW'($urandom_range(0, 300));
         end else if (sel < 80) begin
            v = VW'($urandom_range(301, 4095));
         end else if (sel < 90) begin
            // Squares and near-squares sit right on the divisor bound.
            a = $urandom_range(2, 180);
            v = $urandom_range(1) ? VW'(a * a) : VW'(a * (a + 2));
         end else begin
            v = VW'($urandom_range(16384, 32749)) | VW'(1);
            vd = predict_verdict(v);
            while (!vd.is_prime) begin
               v  = v + VW'(2);
               vd = predict_verdict(v);
            end
         end
         send_word(v, 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d values: %0d prime, %0d not prime, %0d negative, %0d zero.",
               n_prime + n_not_prime + n_negative + n_zero, n_prime, n_not_prime,
               n_negative, n_zero);
      $display("Both streams idled at random, with one stretch of full throughput.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tdp_pkg.sv
rtl/tdp_rem_unit.sv
rtl/trial_division_primality_test_unit.sv
test/tb_trial_division_primality_test_unit.sv
